FILE: src/sslc_pkg.sv
// ----------------------------------------------------------------------------
// sslc_pkg
// Shared types, opcode defaults, command codes and the hex segment table of
// the seven-segment link controller.
// ----------------------------------------------------------------------------
package sslc_pkg;

  // command codes
  localparam logic [1:0] CMD_INIT     = 2'd0;
  localparam logic [1:0] CMD_SET_DISP = 2'd1;
  localparam logic [1:0] CMD_READ_BTN = 2'd2;
  localparam logic [1:0] CMD_PACKET   = 2'd3;

  // result kinds
  localparam logic KIND_TX  = 1'b0;
  localparam logic KIND_BTN = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LED_SET      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LED_USER     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTONS_ON   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_EVENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACKNOWLEDGE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_RESET = 3'd5;

  // opcode reset values
  localparam logic [7:0] RST_LED_SET      = 8'd6;
  localparam logic [7:0] RST_LED_USER     = 8'd17;
  localparam logic [7:0] RST_BUTTONS_ON   = 8'd3;
  localparam logic [7:0] RST_BUTTON_EVENT = 8'd65;
  localparam logic [7:0] RST_ACKNOWLEDGE  = 8'd64;
  localparam logic [7:0] RST_DEVICE_RESET = 8'd66;

  localparam logic [31:0] CLEAR_DISPLAY_WORD = 32'h000F_0000;
  localparam logic [7:0]  BLANK_MASK         = 8'h0F;

  // run buffer sizing
  localparam int RUN_MAX   = 14;
  localparam int RUN_CNT_W = 4;

  // hex digit to segment pattern, entry 0 at the right
  localparam logic [15:0][7:0] SEG_TABLE = {
    8'hE8, 8'hE9, 8'h4F, 8'hE1, 8'h6D, 8'hEE, 8'hAE, 8'hEF,
    8'h86, 8'hED, 8'hAD, 8'h2E, 8'h8F, 8'hCB, 8'h06, 8'hE7
  };

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] display_word;
    logic [7:0]  packet_opcode;
    logic [7:0]  packet_low;
    logic [7:0]  packet_high;
  } sslc_in_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic       last_of_run;
    logic       reset_pending;
  } sslc_out_t;

  typedef struct packed {
    logic [7:0] led_set;
    logic [7:0] led_user;
    logic [7:0] buttons_on;
    logic [7:0] button_event;
    logic [7:0] acknowledge;
    logic [7:0] device_reset;
  } sslc_ops_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_CNT_W-1:0]    len;
    logic                    kind;
    logic                    rp;
  } sslc_run_t;

endpackage

FILE: src/sslc_cfg_regs.sv
// ----------------------------------------------------------------------------
// sslc_cfg_regs
// Opcode register file written through the configuration channel.
// ----------------------------------------------------------------------------
module sslc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [sslc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [7:0]                        wr_data,
  output sslc_pkg::sslc_ops_t               ops
);
  import sslc_pkg::*;

  // register writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ops.led_set      <= RST_LED_SET;
      ops.led_user     <= RST_LED_USER;
      ops.buttons_on   <= RST_BUTTONS_ON;
      ops.button_event <= RST_BUTTON_EVENT;
      ops.acknowledge  <= RST_ACKNOWLEDGE;
      ops.device_reset <= RST_DEVICE_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LED_SET:      ops.led_set      <= wr_data;
        REG_LED_USER:     ops.led_user     <= wr_data;
        REG_BUTTONS_ON:   ops.buttons_on   <= wr_data;
        REG_BUTTON_EVENT: ops.button_event <= wr_data;
        REG_ACKNOWLEDGE:  ops.acknowledge  <= wr_data;
        REG_DEVICE_RESET: ops.device_reset <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/sslc_frame_build.sv
// ----------------------------------------------------------------------------
// sslc_frame_build
// Holds button, display and reset-pending state and composes the byte run
// for one accepted command.
// ----------------------------------------------------------------------------
module sslc_frame_build (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  sslc_pkg::sslc_in_t    item,
  input  sslc_pkg::sslc_ops_t   ops,
  output sslc_pkg::sslc_run_t   run
);
  import sslc_pkg::*;

  logic [7:0]  button_state;
  logic [7:0]  button_state_next;
  logic [31:0] saved_display;
  logic [31:0] saved_display_next;
  logic        reset_flag;
  logic        reset_flag_next;

  logic        is_btn_evt;
  logic        is_ack;
  logic        is_dev_rst;
  logic [31:0] word;
  logic [3:0]  digits;
  logic [3:0]  decs;
  logic [15:0] val;
  logic [3:0][7:0]  segs;
  logic [2:0]       seg_cnt;
  logic [11:0][7:0] frame;
  logic [7:0]       seg_byte;

  // packet decode, button event wins over acknowledge over device reset
  always_comb begin
    is_btn_evt = (item.cmd == CMD_PACKET) && (item.packet_opcode == ops.button_event);
    is_ack     = (item.cmd == CMD_PACKET) && !is_btn_evt
                 && (item.packet_opcode == ops.acknowledge);
    is_dev_rst = (item.cmd == CMD_PACKET) && !is_btn_evt && !is_ack
                 && (item.packet_opcode == ops.device_reset);
  end

  // display word source: replay the saved word on a device reset
  assign word   = is_dev_rst ? saved_display : item.display_word;
  assign val    = word[15:0];
  assign digits = word[19:16];
  assign decs   = word[27:24];

  // pack the segment bytes of the enabled digits, lowest digit first
  always_comb begin
    segs     = '0;
    seg_cnt  = '0;
    seg_byte = '0;
    for (int i = 0; i < 4; i++) begin
      seg_byte = SEG_TABLE[val[4*i +: 4]] | {3'b000, decs[i], 4'b0000};
      if (digits[i]) begin
        segs[seg_cnt[1:0]] = seg_byte;
        seg_cnt            = seg_cnt + 3'd1;
      end
    end
  end

  // blank frame followed by the segment frame
  always_comb begin
    frame     = '0;
    frame[0]  = ops.led_set;
    frame[1]  = BLANK_MASK;
    frame[6]  = ops.led_set;
    frame[7]  = {4'b0000, digits};
    for (int k = 0; k < 4; k++) begin
      frame[8+k] = segs[k];
    end
  end

  // next state
  always_comb begin
    button_state_next  = button_state;
    saved_display_next = saved_display;
    reset_flag_next    = reset_flag;
    priority if (item.cmd == CMD_INIT) begin
      button_state_next  = '0;
      saved_display_next = CLEAR_DISPLAY_WORD;
    end else if (item.cmd == CMD_SET_DISP) begin
      saved_display_next = item.display_word;
    end else if (is_btn_evt) begin
      button_state_next  = {item.packet_high[3:0], item.packet_low[3:0]};
    end else if (is_ack) begin
      reset_flag_next    = 1'b0;
    end else if (is_dev_rst) begin
      reset_flag_next    = 1'b1;
    end else begin
      // button reads and unknown packets keep the state
      reset_flag_next    = reset_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_state  <= '0;
      saved_display <= CLEAR_DISPLAY_WORD;
      reset_flag    <= 1'b0;
    end else if (accept) begin
      button_state  <= button_state_next;
      saved_display <= saved_display_next;
      reset_flag    <= reset_flag_next;
    end
  end

  // run composition, mode prefix shifts the frame by two bytes
  always_comb begin
    run       = '0;
    run.kind  = KIND_TX;
    run.rp    = reset_flag_next;
    if (item.cmd == CMD_READ_BTN) begin
      run.kind     = KIND_BTN;
      run.bytes[0] = button_state;
      run.len      = RUN_CNT_W'(1);
    end else if ((item.cmd == CMD_INIT) || is_dev_rst) begin
      run.bytes[0] = ops.led_user;
      run.bytes[1] = ops.buttons_on;
      for (int k = 0; k < 12; k++) begin
        run.bytes[k+2] = frame[k];
      end
      run.len = (item.cmd == CMD_INIT) ? RUN_CNT_W'(8)
                                       : RUN_CNT_W'(10) + RUN_CNT_W'(seg_cnt);
    end else if (item.cmd == CMD_SET_DISP) begin
      for (int k = 0; k < 12; k++) begin
        run.bytes[k] = frame[k];
      end
      run.len = RUN_CNT_W'(8) + RUN_CNT_W'(seg_cnt);
    end
  end

endmodule

FILE: src/sslc_run_out.sv
// ----------------------------------------------------------------------------
// sslc_run_out
// Run buffer and result register: shifts one byte of the held run into the
// result register per cycle while downstream takes them.
// ----------------------------------------------------------------------------
module sslc_run_out (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  sslc_pkg::sslc_run_t   run_in,
  output logic                  run_free,
  output logic                  res_valid,
  input  logic                  res_stall,
  output sslc_pkg::sslc_out_t   res_data
);
  import sslc_pkg::*;

  logic                 run_valid;
  sslc_run_t            run_buf;
  logic [RUN_CNT_W-1:0] idx;
  logic                 adv;
  logic                 last;

  // move the next byte whenever the result register is free or draining
  assign adv      = run_valid && (!res_valid || !res_stall);
  assign last     = (idx == (run_buf.len - RUN_CNT_W'(1)));
  assign run_free = !run_valid || (adv && last);

  // run buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      run_valid <= 1'b1;
      idx       <= '0;
    end else if (adv && last) begin
      run_valid <= 1'b0;
    end else if (adv) begin
      idx       <= idx + RUN_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_buf <= run_in;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_data.result_kind   <= run_buf.kind;
      res_data.data_byte     <= run_buf.bytes[idx];
      res_data.last_of_run   <= last;
      res_data.reset_pending <= run_buf.rp;
    end
  end

endmodule

FILE: src/seven_segment_link_controller_core.sv
// The first result of a command passes through the run buffer, then the result register.
// Throughput: one result per cycle unless stalled; a command producing n results (1 to 14)
// fills the run buffer, and the next command transfers in the cycle its last byte moves out.
// Commands with no results (button event, acknowledge, unknown packet) do not load the run buffer.
// Reset: synchronous rst restores the opcode defaults, clears buttons and reset-pending, sets
// the saved display word to 0xF0000 and empties the run buffer and result register.
// ----------------------------------------------------------------------------
// seven_segment_link_controller_core
// Host side encoder for a serial keypad and four-digit seven-segment board.
// ----------------------------------------------------------------------------
module seven_segment_link_controller_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  sslc_pkg::sslc_in_t                cmd_data,
  output logic                              res_valid,
  input  logic                              res_stall,
  output sslc_pkg::sslc_out_t               res_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sslc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                        cfg_data
);
  import sslc_pkg::*;

  sslc_ops_t ops;
  sslc_run_t run;
  logic      cmd_accept;
  logic      run_free;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  // a command transfers once the run buffer is free or frees this cycle
  assign cmd_stall  = !run_free;
  assign cmd_accept = cmd_valid && !cmd_stall;

  sslc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .ops      (ops)
  );

  sslc_frame_build u_build (
    .clk    (clk),
    .rst    (rst),
    .accept (cmd_accept),
    .item   (cmd_data),
    .ops    (ops),
    .run    (run)
  );

  sslc_run_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd_accept && (run.len != '0)),
    .run_in    (run),
    .run_free  (run_free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

FILE: src/sslc_checker.sv
// ----------------------------------------------------------------------------
// sslc_checker
// Port-level checks on the result channel of the link controller.
// ----------------------------------------------------------------------------
module sslc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_stall,
  input sslc_pkg::sslc_out_t  res_data
);
  import sslc_pkg::*;

  logic res_xfer;
  assign res_xfer = res_valid && !res_stall;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // a button report is always a run of one
  a_btn_single: assert property (@(posedge clk) disable iff (rst)
    res_xfer && (res_data.result_kind == KIND_BTN) |-> res_data.last_of_run)
    else $error("button report not last of run");

  // inside a run, the next result is a transmit byte with the same flag
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    res_xfer && !res_data.last_of_run |=> !res_valid
      || ((res_data.result_kind == KIND_TX)
          && (res_data.reset_pending == $past(res_data.reset_pending))))
    else $error("run continued with wrong kind or flag");

endmodule

bind seven_segment_link_controller_core sslc_checker u_sslc_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

FILE: dv/seven_segment_link_controller_core_tb.sv
// ----------------------------------------------------------------------------
// seven_segment_link_controller_core_tb
// Self-checking bench for the seven-segment link controller. A directed run
// covers digit tables, decimal points, partial digit masks, button packets,
// device reset replay and unknown opcodes. Random runs follow under several
// opcode settings and idle patterns. Every result transfer is checked
// against a cycle-free model of the encoder.
// ----------------------------------------------------------------------------
module seven_segment_link_controller_core_tb;
  import sslc_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 6;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int NUM_PHASES     = 5;
  localparam int PHASE_ITEMS    = 40;
  localparam int PRINT_CAP      = 100;

  // hex digit to segment pattern, digit 0 leftmost
  localparam logic [0:15][7:0] HEX_SEGMENTS = {
    8'hE7, 8'h06, 8'hCB, 8'h8F, 8'h2E, 8'hAD, 8'hED, 8'h86,
    8'hEF, 8'hAE, 8'hEE, 8'h6D, 8'hE1, 8'h4F, 8'hE9, 8'hE8
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  sslc_in_t             cmd_data = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  sslc_out_t            res_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  // model state
  sslc_ops_t   model_ops = {RST_LED_SET, RST_LED_USER, RST_BUTTONS_ON,
                            RST_BUTTON_EVENT, RST_ACKNOWLEDGE, RST_DEVICE_RESET};
  logic [7:0]  model_buttons = '0;
  logic [31:0] model_saved_word = CLEAR_DISPLAY_WORD;
  logic        model_reset_flag = 1'b0;
  logic [7:0]  tx_run[$];

  sslc_in_t    cmd_backlog[$];
  sslc_out_t   awaited_results[$];
  int          cmds_queued = 0;
  int          cmds_accepted = 0;
  int          mismatch_count = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;

  seven_segment_link_controller_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("*** FAILED ***");
    $finish;
  end

  // blank frame: opcode, all-digit mask, four empty digits
  task automatic add_blank_frame();
    tx_run.push_back(model_ops.led_set);
    tx_run.push_back(BLANK_MASK);
    repeat (4) tx_run.push_back(8'h00);
  endtask

  // save the word, blank the display, then send enabled digits lowest first
  task automatic add_display_frames(input logic [31:0] word);
    logic [7:0] seg;
    model_saved_word = word;
    add_blank_frame();
    tx_run.push_back(model_ops.led_set);
    tx_run.push_back({4'h0, word[19:16]});
    for (int d = 0; d < 4; d++) begin
      if (word[16 + d]) begin
        seg = HEX_SEGMENTS[word[4 * d +: 4]];
        seg[4] = seg[4] | word[24 + d];
        tx_run.push_back(seg);
      end
    end
  endtask

  // work out the results of one accepted command and queue them
  task automatic encode_command(input sslc_in_t c);
    sslc_out_t r;
    tx_run.delete();
    if (c.cmd == CMD_READ_BTN) begin
      r.result_kind   = KIND_BTN;
      r.data_byte     = model_buttons;
      r.last_of_run   = 1'b1;
      r.reset_pending = model_reset_flag;
      awaited_results.push_back(r);
    end else begin
      case (c.cmd)
        CMD_INIT: begin
          model_buttons    = '0;
          model_saved_word = CLEAR_DISPLAY_WORD;
          tx_run.push_back(model_ops.led_user);
          tx_run.push_back(model_ops.buttons_on);
          add_blank_frame();
        end
        CMD_SET_DISP: add_display_frames(c.display_word);
        default: begin
          // opcode priority: button event, acknowledge, device reset
          if (c.packet_opcode == model_ops.button_event) begin
            model_buttons = {c.packet_high[3:0], c.packet_low[3:0]};
          end else if (c.packet_opcode == model_ops.acknowledge) begin
            model_reset_flag = 1'b0;
          end else if (c.packet_opcode == model_ops.device_reset) begin
            model_reset_flag = 1'b1;
            tx_run.push_back(model_ops.led_user);
            tx_run.push_back(model_ops.buttons_on);
            add_display_frames(model_saved_word);
          end
        end
      endcase
      foreach (tx_run[k]) begin
        r.result_kind   = KIND_TX;
        r.data_byte     = tx_run[k];
        r.last_of_run   = (k == tx_run.size() - 1);
        r.reset_pending = model_reset_flag;
        awaited_results.push_back(r);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_result(input sslc_out_t got);
    sslc_out_t want;
    string     diffs;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
    end else begin
      want  = awaited_results.pop_front();
      diffs = "";
      if (got.result_kind !== want.result_kind)
        diffs = {diffs, $sformatf(" result_kind %b exp %b", got.result_kind, want.result_kind)};
      if (got.data_byte !== want.data_byte)
        diffs = {diffs, $sformatf(" data_byte %h exp %h", got.data_byte, want.data_byte)};
      if (got.last_of_run !== want.last_of_run)
        diffs = {diffs, $sformatf(" last_of_run %b exp %b", got.last_of_run, want.last_of_run)};
      if (got.reset_pending !== want.reset_pending)
        diffs = {diffs, $sformatf(" reset_pending %b exp %b",
                                  got.reset_pending, want.reset_pending)};
      if (diffs != "") report_mismatch({"result", diffs});
    end
  endtask

  function automatic sslc_in_t cmd_item(logic [1:0] cmd, logic [31:0] word,
                                        logic [7:0] op, logic [7:0] lo, logic [7:0] hi);
    sslc_in_t c;
    c.cmd           = cmd;
    c.display_word  = word;
    c.packet_opcode = op;
    c.packet_low    = lo;
    c.packet_high   = hi;
    return c;
  endfunction

  // a mix of commands; packets mostly match a configured opcode, some unknown ones
  function automatic sslc_in_t random_command();
    sslc_in_t c;
    int       pick;
    c = cmd_item(CMD_PACKET, $urandom(), 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 15) begin
      c.cmd = CMD_INIT;
    end else if (pick < 50) begin
      c.cmd = CMD_SET_DISP;
    end else if (pick < 70) begin
      c.cmd = CMD_READ_BTN;
    end else begin
      pick = $urandom_range(99);
      if (pick < 40) c.packet_opcode = model_ops.button_event;
      else if (pick < 60) c.packet_opcode = model_ops.acknowledge;
      else if (pick < 85) c.packet_opcode = model_ops.device_reset;
    end
    return c;
  endfunction

  task automatic queue_item(input sslc_in_t c);
    cmd_backlog.push_back(c);
    cmds_queued++;
  endtask

  task automatic wait_for_quiet();
    while (cmds_accepted != cmds_queued || awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all six opcode registers back to back, valid held high throughout
  task automatic load_opcodes(input sslc_ops_t ops);
    logic [7:0] vals[6];
    vals[REG_LED_SET]      = ops.led_set;
    vals[REG_LED_USER]     = ops.led_user;
    vals[REG_BUTTONS_ON]   = ops.buttons_on;
    vals[REG_BUTTON_EVENT] = ops.button_event;
    vals[REG_ACKNOWLEDGE]  = ops.acknowledge;
    vals[REG_DEVICE_RESET] = ops.device_reset;
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    model_ops = ops;
  endtask

  // command driver: one transfer per accepted item, random gaps
  always @(posedge clk) begin : cmd_driver
    logic next_valid;
    next_valid = cmd_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        encode_command(cmd_data);
        cmds_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid && cmd_backlog.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        cmd_data <= cmd_backlog.pop_front();
        next_valid = 1'b1;
      end
    end
    cmd_valid <= next_valid;
  end

  // result monitor with random stall
  always @(posedge clk) begin : res_monitor
    if (!rst && res_valid && !res_stall) check_result(res_data);
    res_stall <= !rst && recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct;
  end

  initial begin : run_sequence
    sslc_ops_t ops;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed run under reset opcodes
    queue_item(cmd_item(CMD_READ_BTN, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
    queue_item(cmd_item(CMD_SET_DISP, 32'h0000_0000, 8'h00, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_SET_DISP, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_SET_DISP, 32'h050F_3210, 8'h00, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_SET_DISP, 32'h0A0F_7654, 8'h00, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_SET_DISP, 32'h000F_BA98, 8'h00, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_SET_DISP, 32'h0F0F_FEDC, 8'h00, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_SET_DISP, 32'h0405_ABCD, 8'h00, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_PACKET, 32'h0, model_ops.button_event, 8'hFF, 8'hFF));
    queue_item(cmd_item(CMD_READ_BTN, 32'h0, 8'h00, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_PACKET, 32'h0, model_ops.button_event, 8'hA5, 8'h5A));
    queue_item(cmd_item(CMD_READ_BTN, 32'h0, 8'h00, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_PACKET, 32'h0, model_ops.device_reset, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_READ_BTN, 32'h0, 8'h00, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_INIT, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
    queue_item(cmd_item(CMD_READ_BTN, 32'h0, 8'h00, 8'h00, 8'h00));
    // replay of the cleared word gives the longest run
    queue_item(cmd_item(CMD_PACKET, 32'h0, model_ops.device_reset, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_PACKET, 32'h0, model_ops.acknowledge, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_READ_BTN, 32'h0, 8'h00, 8'h00, 8'h00));
    // unknown opcodes leave everything alone
    queue_item(cmd_item(CMD_PACKET, 32'h0, 8'h00, 8'hFF, 8'hFF));
    queue_item(cmd_item(CMD_PACKET, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
    queue_item(cmd_item(CMD_READ_BTN, 32'h0, 8'h00, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_INIT, 32'h0, 8'h00, 8'h00, 8'h00));
    queue_item(cmd_item(CMD_SET_DISP, 32'h000A_0000, 8'h00, 8'h00, 8'h00));
    wait_for_quiet();

    // random runs, one opcode setting and idle pattern each
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: ops = {8'hFF, 8'h00, 8'h81, 8'h7E, 8'h01, 8'hFE};
        1: ops = '0;
        2: ops = '1;
        3: begin
          // acknowledge and device reset share an opcode
          ops = 48'({$urandom(), $urandom()});
          ops.button_event = 8'h33;
          ops.acknowledge  = 8'h5C;
          ops.device_reset = 8'h5C;
        end
        default: ops = 48'({$urandom(), $urandom()});
      endcase
      load_opcodes(ops);
      case (phase)
        1: begin sender_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 49; end
        3: begin sender_idle_pct = 23; recv_stall_pct = 23; end
        default: begin sender_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the sender until the link has drained
        if (phase == 3 && n == PHASE_ITEMS / 2) wait_for_quiet();
        queue_item(random_command());
      end
      wait_for_quiet();
    end

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
